// File: rtl/dgt_pkg.sv
// Shared types and constants for the disk geometry translation block.
// Used by dgt_divider and disk_geometry_translation; depends on nothing.
`default_nettype none

package dgt_pkg;

    // Field widths of the input and result words.
    localparam int CYL_W    = 16;
    localparam int HEAD_W   = 16;
    localparam int SEC_W    = 16;
    localparam int LBA_W    = 48;
    localparam int OHEAD_W  = 8;
    localparam int OSEC_W   = 6;

    // Shared divider: dividend, divisor and quotient bits retired per cycle.
    localparam int DIV_DIVIDEND_W     = 24;
    localparam int DIV_DIVISOR_W      = 8;
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = DIV_DIVIDEND_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    // Mode selection limits.
    localparam logic [CYL_W-1:0]  NONE_CYL_LIMIT   = 16'd1024;
    localparam logic [HEAD_W-1:0] NONE_HEAD_LIMIT  = 16'd16;
    localparam logic [SEC_W-1:0]  MAX_SECTORS      = 16'd63;
    localparam logic [31:0]       CH_PRODUCT_LIMIT = 32'd131072;
    localparam logic [LBA_W-1:0]  LBA_LIMIT        = 48'd16450560;

    // Large translation constants.
    localparam logic [CYL_W-1:0]  LARGE_CYL_LIMIT  = 16'd61439;
    localparam logic [HEAD_W-1:0] LARGE_HEADS_16   = 16'd16;
    localparam logic [HEAD_W-1:0] LARGE_HEADS_15   = 16'd15;
    localparam logic [HEAD_W-1:0] HEAD_SHIFT_LIMIT = 16'd127;

    // Physical clamp limits.
    localparam logic [CYL_W-1:0]  CLAMP_CYL  = 16'd1023;
    localparam logic [HEAD_W-1:0] CLAMP_HEAD = 16'd256;

    // LBA-assisted head selection thresholds on the track count.
    localparam logic [DIV_DIVIDEND_W-1:0] TRK_LIMIT_128 = 24'd130944;
    localparam logic [DIV_DIVIDEND_W-1:0] TRK_LIMIT_64  = 24'd65472;
    localparam logic [DIV_DIVIDEND_W-1:0] TRK_LIMIT_32  = 24'd32736;
    localparam logic [DIV_DIVIDEND_W-1:0] TRK_LIMIT_16  = 24'd16368;

    // Translation mode codes as seen on the xlate_mode port.
    typedef enum logic [1:0] {
        XM_NONE    = 2'd0,
        XM_LARGE   = 2'd1,
        XM_LBA     = 2'd2,
        XM_LBA_SAT = 2'd3
    } xlate_mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_LARGE_DIV,
        ST_SHIFT,
        ST_TRACKS,
        ST_CYLS,
        ST_OUTPUT
    } state_t;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// File: rtl/dgt_divider.sv
// Iterative restoring divider shared by the translation sequencer.
// Retires DIV_BITS_PER_CYCLE quotient bits per cycle; depends on dgt_pkg.
`default_nettype none

module dgt_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [dgt_pkg::DIV_DIVIDEND_W-1:0]  dividend,
    input  logic [dgt_pkg::DIV_DIVISOR_W-1:0]   divisor,
    output logic [dgt_pkg::DIV_DIVIDEND_W-1:0]  quotient,
    output dgt_pkg::div_status_t                status
);
    import dgt_pkg::*;

    logic                       busy_reg;
    logic                       done_reg;
    logic [DIV_CNT_W-1:0]       cnt_reg;
    logic [DIV_DIVISOR_W-1:0]   rem_reg;
    logic [DIV_DIVISOR_W-1:0]   rem_next;
    logic [DIV_DIVIDEND_W-1:0]  quo_reg;
    logic [DIV_DIVIDEND_W-1:0]  quo_next;
    logic [DIV_DIVISOR_W-1:0]   dsr_reg;

    // Several conditional-subtract steps per cycle on a narrow remainder.
    always_comb
    begin
        logic [DIV_DIVISOR_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial    = {rem_next, quo_next[DIV_DIVIDEND_W-1]};
            quo_next = {quo_next[DIV_DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial       = trial - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DIV_DIVISOR_W-1:0];
        end
    end

    // Control: busy while the step counter runs, then a one-cycle done word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: load operands on start, then shift and subtract.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/disk_geometry_translation.sv
// Top level of the disk geometry translation block: sequencer and result register.
// Depends on dgt_pkg and dgt_divider.
//
// Usage: one input word carries a drive's reported cylinders, heads, sectors per
// track, total sector count and a floppy flag. The block answers with one result
// word holding physical and logical geometry, the translation mode and a
// translated flag. Both channels use valid/ready; a word moves when both are high.
// in_ready is high only while the sequencer is idle, so one word is in work at a time.
// The shared divider retires four quotient bits per cycle; LBA-assisted mode divides
// twice (by 63, then by the head count). Large mode with sixteen heads divides once by
// 15 and then halves at most four times; otherwise its halving loop runs up to six
// steps and a final check. Without translation or with saturated LBA translation the
// sequencer goes from the classify state straight to the output state, with no division.
// A new word is accepted the cycle after the previous result is loaded into the
// output register. Only the final load waits for the output register to be free.
// Reset clears the sequencer, the divider control and out_valid; the block is
// ready right after reset is released.
`default_nettype none

module disk_geometry_translation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            is_floppy,
    input  logic [dgt_pkg::CYL_W-1:0]       cyl_count,
    input  logic [dgt_pkg::HEAD_W-1:0]      head_count,
    input  logic [dgt_pkg::SEC_W-1:0]       sectors_per_track,
    input  logic [dgt_pkg::LBA_W-1:0]       total_sectors,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dgt_pkg::CYL_W-1:0]       phys_cyl_max,
    output logic [dgt_pkg::OHEAD_W-1:0]     phys_head_max,
    output logic [dgt_pkg::OSEC_W-1:0]      phys_sectors,
    output logic [dgt_pkg::CYL_W-1:0]       log_cyl_max,
    output logic [dgt_pkg::OHEAD_W-1:0]     log_head_max,
    output logic [dgt_pkg::OSEC_W-1:0]      log_sectors,
    output logic [1:0]                      xlate_mode,
    output logic                            translated
);
    import dgt_pkg::*;

    state_t                     state_reg, state_next;
    xlate_mode_t                mode_reg, mode_next;
    logic                       floppy_reg;
    logic [CYL_W-1:0]           c_reg;
    logic [HEAD_W-1:0]          h_reg;
    logic [SEC_W-1:0]           s_reg;
    logic [LBA_W-1:0]           lba_reg;
    logic [CYL_W-1:0]           cyl_reg, cyl_next;
    logic [HEAD_W-1:0]          hds_reg, hds_next;

    logic                       div_start;
    logic [DIV_DIVIDEND_W-1:0]  div_dividend;
    logic [DIV_DIVISOR_W-1:0]   div_divisor;
    logic [DIV_DIVIDEND_W-1:0]  div_quotient;
    div_status_t                div_status;

    logic                       in_accept;
    logic                       out_load;
    logic                       geo_zero;
    logic                       fits_none;
    logic [31:0]                ch_product;
    logic                       large_ok;
    logic                       lba_sat;
    logic [CYL_W-1:0]           large_cyl;
    logic [HEAD_W-1:0]          hds_shifted;
    logic [DIV_DIVISOR_W-1:0]   lba_heads;

    logic [CYL_W-1:0]           pc_clamp;
    logic [OHEAD_W-1:0]         ph_clamp;
    logic [OSEC_W-1:0]          ps_clamp;
    logic [CYL_W-1:0]           res_phys_cyl, res_log_cyl;
    logic [OHEAD_W-1:0]         res_phys_head, res_log_head;
    logic [OSEC_W-1:0]          res_phys_sec, res_log_sec;

    logic                       out_valid_reg;
    logic [CYL_W-1:0]           phys_cyl_reg, log_cyl_reg;
    logic [OHEAD_W-1:0]         phys_head_reg, log_head_reg;
    logic [OSEC_W-1:0]          phys_sec_reg, log_sec_reg;
    logic [1:0]                 mode_out_reg;
    logic                       translated_reg;

    // Shared divider.
    dgt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // Mode classification terms on the captured input word.
    assign geo_zero   = ((c_reg == '0) || (h_reg == '0) || (s_reg == '0)) && !floppy_reg;
    assign fits_none  = (c_reg <= NONE_CYL_LIMIT) && (h_reg <= NONE_HEAD_LIMIT) &&
                        (s_reg <= MAX_SECTORS);
    assign ch_product = c_reg * h_reg;
    assign large_ok   = (ch_product <= CH_PRODUCT_LIMIT);
    assign lba_sat    = (lba_reg > LBA_LIMIT);
    assign large_cyl  = (c_reg > LARGE_CYL_LIMIT) ? LARGE_CYL_LIMIT : c_reg;
    assign hds_shifted = {hds_reg[HEAD_W-2:0], 1'b0};

    // Head count chosen from the track count held in the divider.
    always_comb
    begin
        if (div_quotient > TRK_LIMIT_128)
            lba_heads = 8'd255;
        else if (div_quotient > TRK_LIMIT_64)
            lba_heads = 8'd128;
        else if (div_quotient > TRK_LIMIT_32)
            lba_heads = 8'd64;
        else if (div_quotient > TRK_LIMIT_16)
            lba_heads = 8'd32;
        else
            lba_heads = 8'd16;
    end

    // Sequencer: next state, working registers and divider commands.
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        cyl_next     = cyl_reg;
        hds_next     = hds_reg;
        div_start    = 1'b0;
        div_dividend = {{(DIV_DIVIDEND_W - CYL_W - 4){1'b0}}, large_cyl, 4'b0000};
        div_divisor  = LARGE_HEADS_15[DIV_DIVISOR_W-1:0];
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                cyl_next = c_reg;
                hds_next = h_reg;
                if (!geo_zero && fits_none)
                begin
                    mode_next  = XM_NONE;
                    state_next = ST_OUTPUT;
                end
                else if (!geo_zero && large_ok)
                begin
                    mode_next = XM_LARGE;
                    if (h_reg == LARGE_HEADS_16)
                    begin
                        hds_next   = LARGE_HEADS_15;
                        div_start  = 1'b1;
                        state_next = ST_LARGE_DIV;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (lba_sat)
                begin
                    mode_next  = XM_LBA_SAT;
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    mode_next    = XM_LBA;
                    div_start    = 1'b1;
                    div_dividend = lba_reg[DIV_DIVIDEND_W-1:0];
                    div_divisor  = MAX_SECTORS[DIV_DIVISOR_W-1:0];
                    state_next   = ST_TRACKS;
                end
            end
            ST_LARGE_DIV:
            begin
                if (div_status.done)
                begin
                    cyl_next   = div_quotient[CYL_W-1:0];
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (cyl_reg > NONE_CYL_LIMIT)
                begin
                    cyl_next = {1'b0, cyl_reg[CYL_W-1:1]};
                    hds_next = hds_shifted;
                    if (hds_shifted > HEAD_SHIFT_LIMIT)
                        state_next = ST_OUTPUT;
                end
                else
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_TRACKS:
            begin
                if (div_status.done)
                begin
                    hds_next     = {{(HEAD_W - DIV_DIVISOR_W){1'b0}}, lba_heads};
                    div_start    = 1'b1;
                    div_dividend = div_quotient;
                    div_divisor  = lba_heads;
                    state_next   = ST_CYLS;
                end
            end
            ST_CYLS:
            begin
                if (div_status.done)
                begin
                    cyl_next   = div_quotient[CYL_W-1:0];
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Physical geometry clamp used by large and LBA-assisted modes.
    assign pc_clamp = (c_reg >= NONE_CYL_LIMIT) ? CLAMP_CYL : c_reg;
    assign ph_clamp = (h_reg >= CLAMP_HEAD) ? 8'd255 : h_reg[OHEAD_W-1:0];
    assign ps_clamp = (s_reg >= MAX_SECTORS) ? MAX_SECTORS[OSEC_W-1:0] : s_reg[OSEC_W-1:0];

    // Result word assembled from the working registers.
    always_comb
    begin
        res_phys_cyl  = pc_clamp - 1'b1;
        res_phys_head = ph_clamp - 1'b1;
        res_phys_sec  = ps_clamp;
        res_log_cyl   = cyl_reg - 1'b1;
        res_log_head  = hds_reg[OHEAD_W-1:0] - 1'b1;
        res_log_sec   = ps_clamp;
        unique case (mode_reg)
            XM_NONE:
            begin
                res_phys_cyl  = c_reg - 1'b1;
                res_phys_head = h_reg[OHEAD_W-1:0] - 1'b1;
                res_phys_sec  = s_reg[OSEC_W-1:0];
                res_log_cyl   = res_phys_cyl;
                res_log_head  = res_phys_head;
                res_log_sec   = res_phys_sec;
            end
            XM_LARGE:
            begin
                res_log_sec = ps_clamp;
            end
            XM_LBA:
            begin
                res_log_sec = MAX_SECTORS[OSEC_W-1:0];
            end
            XM_LBA_SAT:
            begin
                res_phys_cyl  = CLAMP_CYL;
                res_phys_head = 8'd255;
                res_phys_sec  = MAX_SECTORS[OSEC_W-1:0];
                res_log_cyl   = CLAMP_CYL;
                res_log_head  = 8'd255;
                res_log_sec   = MAX_SECTORS[OSEC_W-1:0];
            end
            default:
            begin
                res_log_sec = ps_clamp;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Input capture and working registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            floppy_reg <= is_floppy;
            c_reg      <= cyl_count;
            h_reg      <= head_count;
            s_reg      <= sectors_per_track;
            lba_reg    <= total_sectors;
        end
        mode_reg <= mode_next;
        cyl_reg  <= cyl_next;
        hds_reg  <= hds_next;
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            phys_cyl_reg   <= res_phys_cyl;
            phys_head_reg  <= res_phys_head;
            phys_sec_reg   <= res_phys_sec;
            log_cyl_reg    <= res_log_cyl;
            log_head_reg   <= res_log_head;
            log_sec_reg    <= res_log_sec;
            mode_out_reg   <= mode_reg;
            translated_reg <= (mode_reg != XM_NONE);
        end
    end

    assign out_valid     = out_valid_reg;
    assign phys_cyl_max  = phys_cyl_reg;
    assign phys_head_max = phys_head_reg;
    assign phys_sectors  = phys_sec_reg;
    assign log_cyl_max   = log_cyl_reg;
    assign log_head_max  = log_head_reg;
    assign log_sectors   = log_sec_reg;
    assign xlate_mode    = mode_out_reg;
    assign translated    = translated_reg;

`ifndef ASSERT_OFF
    // The divider is only started while it is idle.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // An idle sequencer never leaves a division running.
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_status.busy)
        else $error("divider busy while sequencer idle");

    // The translated flag agrees with the reported mode.
    a_translated_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (translated == (xlate_mode != XM_NONE)))
        else $error("translated flag does not match mode");

    // LBA-assisted results always report 63 logical sectors.
    a_lba_sectors: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((xlate_mode == XM_LBA) || (xlate_mode == XM_LBA_SAT)))
            |-> (log_sectors == MAX_SECTORS[OSEC_W-1:0]))
        else $error("LBA mode with logical sectors other than 63");
`endif

endmodule

`default_nettype wire
